>>> rtl/vat3d_pkg.sv
// Shared constants, codes and control types for the 3-D vertex transform unit.
package vat3d_pkg;

  localparam int unsigned COEF_BITS    = 16;
  localparam int unsigned MODE_BITS    = 3;
  localparam int unsigned AXIS_BITS    = 2;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned NUM_LANES    = 3;

  localparam logic [MODE_BITS-1:0] MODE_TRANSLATE = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_SCALE     = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_ROTATE    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_REFLECT   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_SHEAR     = 3'd4;

  localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PARAM_X     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PARAM_Y     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PARAM_Z     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FIRST  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_SECOND = 3'd6;

  // Per-lane arithmetic control: subtract second product, scale down by 2^FRAC_BITS.
  typedef struct packed {
    logic sub;
    logic frac;
  } lane_ctl_t;

  // Per-stage load enables of the datapath.
  typedef struct packed {
    logic op;
    logic mul;
    logic sum;
    logic out;
  } pipe_adv_t;

endpackage

>>> rtl/vat3d_opsel.sv
// Operand selection: maps mode and axis onto two products and an addend per lane.
module vat3d_opsel #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned KW         = 16,
  parameter int unsigned AW         = 28
) (
  input  logic signed [COORD_BITS-1:0]            coord_i       [vat3d_pkg::NUM_LANES],
  input  logic signed [COORD_BITS-1:0]            param_i       [vat3d_pkg::NUM_LANES],
  input  logic signed [vat3d_pkg::COEF_BITS-1:0]  coef_first_i,
  input  logic signed [vat3d_pkg::COEF_BITS-1:0]  coef_second_i,
  input  logic        [vat3d_pkg::MODE_BITS-1:0]  mode_i,
  input  logic        [vat3d_pkg::AXIS_BITS-1:0]  axis_i,
  output logic signed [COORD_BITS-1:0]            a1_o          [vat3d_pkg::NUM_LANES],
  output logic signed [KW-1:0]                    b1_o          [vat3d_pkg::NUM_LANES],
  output logic signed [COORD_BITS-1:0]            a2_o          [vat3d_pkg::NUM_LANES],
  output logic signed [KW-1:0]                    b2_o          [vat3d_pkg::NUM_LANES],
  output logic signed [AW-1:0]                    add_o         [vat3d_pkg::NUM_LANES],
  output vat3d_pkg::lane_ctl_t                    ctl_o         [vat3d_pkg::NUM_LANES]
);

  localparam int unsigned LX = 0;
  localparam int unsigned LY = 1;
  localparam int unsigned LZ = 2;

  logic signed [KW-1:0] c_ext;
  logic signed [KW-1:0] s_ext;

  assign c_ext = KW'(coef_first_i);
  assign s_ext = KW'(coef_second_i);

  always_comb begin
    // Default: pass the coordinate through as coord * 1.
    for (int k = 0; k < vat3d_pkg::NUM_LANES; k++) begin
      a1_o[k]       = coord_i[k];
      b1_o[k]       = KW'(1);
      a2_o[k]       = '0;
      b2_o[k]       = '0;
      add_o[k]      = '0;
      ctl_o[k].sub  = 1'b0;
      ctl_o[k].frac = 1'b0;
    end

    case (mode_i)
      vat3d_pkg::MODE_TRANSLATE: begin
        for (int k = 0; k < vat3d_pkg::NUM_LANES; k++) begin
          add_o[k] = AW'(param_i[k]);
        end
      end
      vat3d_pkg::MODE_SCALE: begin
        for (int k = 0; k < vat3d_pkg::NUM_LANES; k++) begin
          b1_o[k] = KW'(param_i[k]);
        end
      end
      vat3d_pkg::MODE_ROTATE: begin
        case (axis_i)
          vat3d_pkg::AXIS_Z: begin
            a1_o[LX] = coord_i[LX]; b1_o[LX] = c_ext;
            a2_o[LX] = coord_i[LY]; b2_o[LX] = s_ext;
            ctl_o[LX].sub = 1'b1; ctl_o[LX].frac = 1'b1;
            a1_o[LY] = coord_i[LX]; b1_o[LY] = s_ext;
            a2_o[LY] = coord_i[LY]; b2_o[LY] = c_ext;
            ctl_o[LY].frac = 1'b1;
          end
          vat3d_pkg::AXIS_Y: begin
            a1_o[LZ] = coord_i[LZ]; b1_o[LZ] = c_ext;
            a2_o[LZ] = coord_i[LX]; b2_o[LZ] = s_ext;
            ctl_o[LZ].sub = 1'b1; ctl_o[LZ].frac = 1'b1;
            a1_o[LX] = coord_i[LZ]; b1_o[LX] = s_ext;
            a2_o[LX] = coord_i[LX]; b2_o[LX] = c_ext;
            ctl_o[LX].frac = 1'b1;
          end
          vat3d_pkg::AXIS_X: begin
            a1_o[LY] = coord_i[LY]; b1_o[LY] = c_ext;
            a2_o[LY] = coord_i[LZ]; b2_o[LY] = s_ext;
            ctl_o[LY].sub = 1'b1; ctl_o[LY].frac = 1'b1;
            a1_o[LZ] = coord_i[LY]; b1_o[LZ] = s_ext;
            a2_o[LZ] = coord_i[LZ]; b2_o[LZ] = c_ext;
            ctl_o[LZ].frac = 1'b1;
          end
          default: ;  // undefined axis: vertex passes unchanged
        endcase
      end
      vat3d_pkg::MODE_REFLECT: begin
        case (axis_i)
          vat3d_pkg::AXIS_Z: b1_o[LZ] = '1;
          vat3d_pkg::AXIS_X: b1_o[LX] = '1;
          default:           b1_o[LY] = '1;
        endcase
      end
      vat3d_pkg::MODE_SHEAR: begin
        // Base coordinate enters as coord << FRAC_BITS; the sum is truncated whole.
        case (axis_i)
          vat3d_pkg::AXIS_Z: begin
            add_o[LX] = $signed({coord_i[LX], {FRAC_BITS{1'b0}}});
            a1_o[LX]  = coord_i[LZ]; b1_o[LX] = c_ext; ctl_o[LX].frac = 1'b1;
            add_o[LY] = $signed({coord_i[LY], {FRAC_BITS{1'b0}}});
            a1_o[LY]  = coord_i[LZ]; b1_o[LY] = s_ext; ctl_o[LY].frac = 1'b1;
          end
          vat3d_pkg::AXIS_X: begin
            add_o[LX] = $signed({coord_i[LX], {FRAC_BITS{1'b0}}});
            a1_o[LX]  = coord_i[LY]; b1_o[LX] = c_ext; ctl_o[LX].frac = 1'b1;
            add_o[LZ] = $signed({coord_i[LZ], {FRAC_BITS{1'b0}}});
            a1_o[LZ]  = coord_i[LY]; b1_o[LZ] = s_ext; ctl_o[LZ].frac = 1'b1;
          end
          default: begin
            add_o[LY] = $signed({coord_i[LY], {FRAC_BITS{1'b0}}});
            a1_o[LY]  = coord_i[LX]; b1_o[LY] = c_ext; ctl_o[LY].frac = 1'b1;
            add_o[LZ] = $signed({coord_i[LZ], {FRAC_BITS{1'b0}}});
            a1_o[LZ]  = coord_i[LX]; b1_o[LZ] = s_ext; ctl_o[LZ].frac = 1'b1;
          end
        endcase
      end
      default: ;  // unused modes: vertex passes unchanged
    endcase
  end

endmodule

>>> rtl/vat3d_lane.sv
// One coordinate lane: operand, multiply, sum and round/clamp register stages.
module vat3d_lane #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned KW         = 16,
  parameter int unsigned AW         = 28
) (
  input  logic                         clk_i,
  input  vat3d_pkg::pipe_adv_t         adv_i,
  input  logic signed [COORD_BITS-1:0] a1_i,
  input  logic signed [KW-1:0]         b1_i,
  input  logic signed [COORD_BITS-1:0] a2_i,
  input  logic signed [KW-1:0]         b2_i,
  input  logic signed [AW-1:0]         add_i,
  input  vat3d_pkg::lane_ctl_t         ctl_i,
  output logic signed [COORD_BITS-1:0] coord_o,
  output logic                         sat_o
);

  localparam int unsigned PW = COORD_BITS + KW;
  localparam int unsigned SW = PW + 2;

  localparam logic signed [SW-1:0] BIAS = {{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [SW-1:0] CMAX = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  // Operand stage
  logic signed [COORD_BITS-1:0] a1_q, a2_q;
  logic signed [KW-1:0]         b1_q, b2_q;
  logic signed [AW-1:0]         add_q;
  vat3d_pkg::lane_ctl_t         ctl_q;

  // Multiply stage
  logic signed [PW-1:0] p1_d, p2_d, p1_q, p2_q;
  logic signed [AW-1:0] add_m_q;
  vat3d_pkg::lane_ctl_t ctl_m_q;

  // Sum stage
  logic signed [SW-1:0] sum_d, sum_q;
  logic                 frac_s_q;

  // Output stage
  logic signed [SW-1:0]         biased;
  logic signed [SW-1:0]         val;
  logic signed [COORD_BITS-1:0] coord_d, coord_q;
  logic                         sat_d, sat_q;

  assign p1_d = a1_q * b1_q;
  assign p2_d = a2_q * b2_q;

  always_comb begin
    if (ctl_m_q.sub) begin
      sum_d = SW'(add_m_q) + SW'(p1_q) - SW'(p2_q);
    end else begin
      sum_d = SW'(add_m_q) + SW'(p1_q) + SW'(p2_q);
    end
  end

  // Truncate toward zero: bias negative sums by 2^FRAC_BITS - 1 before the shift.
  assign biased = sum_q[SW-1] ? (sum_q + BIAS) : sum_q;
  assign val    = frac_s_q ? (biased >>> FRAC_BITS) : sum_q;

  always_comb begin
    if (val > CMAX) begin
      coord_d = CMAX[COORD_BITS-1:0];
      sat_d   = 1'b1;
    end else if (val < CMIN) begin
      coord_d = CMIN[COORD_BITS-1:0];
      sat_d   = 1'b1;
    end else begin
      coord_d = val[COORD_BITS-1:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.op) begin
      a1_q  <= a1_i;
      b1_q  <= b1_i;
      a2_q  <= a2_i;
      b2_q  <= b2_i;
      add_q <= add_i;
      ctl_q <= ctl_i;
    end
    if (adv_i.mul) begin
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      add_m_q <= add_q;
      ctl_m_q <= ctl_q;
    end
    if (adv_i.sum) begin
      sum_q    <= sum_d;
      frac_s_q <= ctl_m_q.frac;
    end
    if (adv_i.out) begin
      coord_q <= coord_d;
      sat_q   <= sat_d;
    end
  end

  assign coord_o = coord_q;
  assign sat_o   = sat_q;

endmodule

>>> rtl/vertex_affine_transform_3d_unit.sv
// Top level of the 3-D affine vertex transform: config registers, valid chain, three lanes.
//
// One vertex enters per clock unless the output stalls, and its result passes the
// operand, multiply, sum and round/clamp registers; each stage holds its own valid
// bit, so a stall at the output fills bubbles before it pushes back on the input.
// Every coordinate lane has two multipliers of COORD_BITS by max(COORD_BITS, 16)
// bits, which set the throughput to one vertex per cycle without a stall. Rotate
// and shear divide the full sum by 2^FRAC_BITS with truncation toward zero; all
// results saturate to COORD_BITS signed bits and the tuser flag marks a clamped
// vertex. Write the configuration registers only while no vertex is in flight.
module vertex_affine_transform_3d_unit #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // x_in, y_in, z_in from bit 0 up, zero padded to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]         s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // x_out, y_out, z_out from bit 0 up, zero padded to bytes
  output logic [((3*COORD_BITS+7)/8)*8-1:0]         m_axis_tdata,
  // saturated
  output logic                                      m_axis_tuser,
  input  logic                                      cfg_we_i,
  input  logic [vat3d_pkg::CFG_IDX_BITS-1:0]        cfg_idx_i,
  input  logic [((COORD_BITS > vat3d_pkg::COEF_BITS) ?
                 COORD_BITS : vat3d_pkg::COEF_BITS)-1:0] cfg_data_i
);

  localparam int unsigned KW   = (COORD_BITS > vat3d_pkg::COEF_BITS) ?
                                 COORD_BITS : vat3d_pkg::COEF_BITS;
  localparam int unsigned AW   = COORD_BITS + FRAC_BITS;
  localparam int unsigned TD_W = ((3*COORD_BITS+7)/8)*8;
  localparam int unsigned PADW = TD_W - 3*COORD_BITS;
  localparam int unsigned NL   = vat3d_pkg::NUM_LANES;
  localparam int unsigned NST  = 4;

  localparam logic signed [vat3d_pkg::COEF_BITS-1:0] COEF_ONE =
    vat3d_pkg::COEF_BITS'(1) << FRAC_BITS;

  // Configuration registers
  logic        [vat3d_pkg::MODE_BITS-1:0] mode_q;
  logic        [vat3d_pkg::AXIS_BITS-1:0] axis_q;
  logic signed [COORD_BITS-1:0]           param_q [NL];
  logic signed [vat3d_pkg::COEF_BITS-1:0] coef_first_q, coef_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= vat3d_pkg::MODE_TRANSLATE;
      axis_q        <= vat3d_pkg::AXIS_X;
      param_q[0]    <= '0;
      param_q[1]    <= '0;
      param_q[2]    <= '0;
      coef_first_q  <= COEF_ONE;
      coef_second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vat3d_pkg::REG_MODE:        mode_q        <= cfg_data_i[vat3d_pkg::MODE_BITS-1:0];
        vat3d_pkg::REG_AXIS:        axis_q        <= cfg_data_i[vat3d_pkg::AXIS_BITS-1:0];
        vat3d_pkg::REG_PARAM_X:     param_q[0]    <= cfg_data_i[COORD_BITS-1:0];
        vat3d_pkg::REG_PARAM_Y:     param_q[1]    <= cfg_data_i[COORD_BITS-1:0];
        vat3d_pkg::REG_PARAM_Z:     param_q[2]    <= cfg_data_i[COORD_BITS-1:0];
        vat3d_pkg::REG_COEF_FIRST:  coef_first_q  <= cfg_data_i[vat3d_pkg::COEF_BITS-1:0];
        vat3d_pkg::REG_COEF_SECOND: coef_second_q <= cfg_data_i[vat3d_pkg::COEF_BITS-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Valid chain: a stage loads when it is empty or the stage after it moves.
  logic [NST-1:0] vld_q, vld_d;
  logic [NST:0]   rdy;
  vat3d_pkg::pipe_adv_t adv;

  always_comb begin
    rdy[NST] = m_axis_tready;
    for (int k = NST-1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign adv.op  = rdy[0];
  assign adv.mul = rdy[1];
  assign adv.sum = rdy[2];
  assign adv.out = rdy[3];

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NST-1];

  // Operand selection
  logic signed [COORD_BITS-1:0] coord_in [NL];
  logic signed [COORD_BITS-1:0] a1 [NL], a2 [NL];
  logic signed [KW-1:0]         b1 [NL], b2 [NL];
  logic signed [AW-1:0]         add [NL];
  vat3d_pkg::lane_ctl_t         ctl [NL];
  logic signed [COORD_BITS-1:0] coord_out [NL];
  logic        [NL-1:0]         sat;

  for (genvar g = 0; g < NL; g++) begin : g_unpack
    assign coord_in[g] = s_axis_tdata[g*COORD_BITS +: COORD_BITS];
  end

  vat3d_opsel #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .KW         (KW),
    .AW         (AW)
  ) u_opsel (
    .coord_i       (coord_in),
    .param_i       (param_q),
    .coef_first_i  (coef_first_q),
    .coef_second_i (coef_second_q),
    .mode_i        (mode_q),
    .axis_i        (axis_q),
    .a1_o          (a1),
    .b1_o          (b1),
    .a2_o          (a2),
    .b2_o          (b2),
    .add_o         (add),
    .ctl_o         (ctl)
  );

  for (genvar g = 0; g < NL; g++) begin : g_lane
    vat3d_lane #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .KW         (KW),
      .AW         (AW)
    ) u_lane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .a1_i    (a1[g]),
      .b1_i    (b1[g]),
      .a2_i    (a2[g]),
      .b2_i    (b2[g]),
      .add_i   (add[g]),
      .ctl_i   (ctl[g]),
      .coord_o (coord_out[g]),
      .sat_o   (sat[g])
    );
    assign m_axis_tdata[g*COORD_BITS +: COORD_BITS] = coord_out[g];
  end

  if (PADW > 0) begin : g_pad
    assign m_axis_tdata[TD_W-1 -: PADW] = '0;
  end

  assign m_axis_tuser = |sat;

endmodule

>>> rtl/vat3d_checker.sv
// Port-level checker for the vertex transform unit, bound to the top level.
module vat3d_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((3*COORD_BITS+7)/8)*8-1:0]   m_axis_tdata,
  input logic                                m_axis_tuser
);

  localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [COORD_BITS-1:0] xo, yo, zo;
  assign xo = m_axis_tdata[0 +: COORD_BITS];
  assign yo = m_axis_tdata[COORD_BITS +: COORD_BITS];
  assign zo = m_axis_tdata[2*COORD_BITS +: COORD_BITS];

  // A stalled word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                         && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // An open output never blocks the input.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  // With the output open, an accepted word appears after the pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after pipeline depth");

  // A clamp flag implies some coordinate sits at a range limit.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (xo == CMAX) || (xo == CMIN) || (yo == CMAX) || (yo == CMIN) ||
      (zo == CMAX) || (zo == CMIN))
    else $error("saturation flag without clamped coordinate");

endmodule

bind vertex_affine_transform_3d_unit vat3d_checker #(
  .COORD_BITS (COORD_BITS)
) u_vat3d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/vertex_affine_transform_3d_unit_tb.sv
// Self-checking testbench for the 3-D affine vertex transform unit.
module vertex_affine_transform_3d_unit_tb;
  import vat3d_pkg::*;

  localparam int COORD_W        = 16;
  localparam int DATA_W         = ((3 * COORD_W + 7) / 8) * 8;
  localparam int FRAC_W         = 12;
  localparam longint FRAC_ONE   = 64'sd1 << FRAC_W;
  localparam longint COORD_HI   = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO   = -COORD_HI - 1;
  localparam int PIPE_LATENCY   = 4;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int QUIET_PHASE    = 6;
  localparam int PRINT_LIMIT    = 40;

  // Spare encodings that the block must tolerate.
  localparam logic [MODE_BITS-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [AXIS_BITS-1:0] AXIS_SPARE       = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER [7] = '{REG_MODE, REG_AXIS, REG_PARAM_X,
      REG_PARAM_Y, REG_PARAM_Z, REG_COEF_FIRST, REG_COEF_SECOND};

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic    sat;
    vertex_t pos;
  } transform_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]       mode;
    logic [AXIS_BITS-1:0]       axis;
    logic signed [COORD_W-1:0]  param_x;
    logic signed [COORD_W-1:0]  param_y;
    logic signed [COORD_W-1:0]  param_z;
    logic signed [COEF_BITS-1:0] coef_first;
    logic signed [COEF_BITS-1:0] coef_second;
  } setup_t;

  typedef struct {
    setup_t     cfg;
    vertex_t    pos;
    bit         typed;
    transform_t result;
  } vector_t;

  typedef logic [COEF_BITS-1:0] reg_file_t [7];

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // x_in, y_in, z_in from bit 0 up
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // x_out, y_out, z_out from bit 0 up
  logic [DATA_W-1:0] m_axis_tdata;
  // saturated
  logic              m_axis_tuser;
  logic                    cfg_we   = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx  = REG_MODE;
  logic [COEF_BITS-1:0]    cfg_data = '0;

  transform_t pending_results [$];
  setup_t     active;
  int         src_idle_pct  = 33;
  int         sink_idle_pct = 33;
  int         hold_requests = 0;
  int         holds_seen    = 0;
  int         hold_left     = 0;
  int         stuck_cycles  = 0;
  int         vertices_sent = 0;
  int         results_checked = 0;
  int         mismatches    = 0;

  vertex_affine_transform_3d_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI[COORD_W-1:0];
    if (v < COORD_LO) return COORD_LO[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  function automatic transform_t predict_vertex(input setup_t s, input vertex_t v);
    longint x  = v.x;
    longint y  = v.y;
    longint z  = v.z;
    longint px = s.param_x;
    longint py = s.param_y;
    longint pz = s.param_z;
    longint c  = s.coef_first;
    longint sn = s.coef_second;
    longint nx = x;
    longint ny = y;
    longint nz = z;
    transform_t r;
    case (s.mode)
      MODE_TRANSLATE: begin
        nx = x + px; ny = y + py; nz = z + pz;
      end
      MODE_SCALE: begin
        nx = x * px; ny = y * py; nz = z * pz;
      end
      MODE_ROTATE: begin
        if (s.axis == AXIS_Z) begin
          nx = (x * c - y * sn) / FRAC_ONE;
          ny = (x * sn + y * c) / FRAC_ONE;
        end else if (s.axis == AXIS_Y) begin
          nz = (z * c - x * sn) / FRAC_ONE;
          nx = (z * sn + x * c) / FRAC_ONE;
        end else if (s.axis == AXIS_X) begin
          ny = (y * c - z * sn) / FRAC_ONE;
          nz = (y * sn + z * c) / FRAC_ONE;
        end
      end
      MODE_REFLECT: begin
        if (s.axis == AXIS_Z) nz = -z;
        else if (s.axis == AXIS_X) nx = -x;
        else ny = -y;
      end
      MODE_SHEAR: begin
        // truncate the whole sum, not the sheared term alone
        if (s.axis == AXIS_Z) begin
          nx = (x * FRAC_ONE + c * z) / FRAC_ONE;
          ny = (y * FRAC_ONE + sn * z) / FRAC_ONE;
        end else if (s.axis == AXIS_X) begin
          nx = (x * FRAC_ONE + c * y) / FRAC_ONE;
          nz = (z * FRAC_ONE + sn * y) / FRAC_ONE;
        end else begin
          ny = (y * FRAC_ONE + c * x) / FRAC_ONE;
          nz = (z * FRAC_ONE + sn * x) / FRAC_ONE;
        end
      end
      default: ;
    endcase
    r.pos.x = clamp_coord(nx);
    r.pos.y = clamp_coord(ny);
    r.pos.z = clamp_coord(nz);
    r.sat = (nx > COORD_HI) || (nx < COORD_LO) || (ny > COORD_HI) || (ny < COORD_LO) ||
            (nz > COORD_HI) || (nz < COORD_LO);
    return r;
  endfunction

  function automatic setup_t mk_setup(input logic [MODE_BITS-1:0] mode,
                                      input logic [AXIS_BITS-1:0] axis,
                                      input int px, input int py, input int pz,
                                      input int cf, input int cs);
    setup_t s;
    s.mode = mode;
    s.axis = axis;
    s.param_x = px[COORD_W-1:0];
    s.param_y = py[COORD_W-1:0];
    s.param_z = pz[COORD_W-1:0];
    s.coef_first = cf[COEF_BITS-1:0];
    s.coef_second = cs[COEF_BITS-1:0];
    return s;
  endfunction

  function automatic vertex_t vtx(input int x, input int y, input int z);
    vertex_t v;
    v.x = x[COORD_W-1:0];
    v.y = y[COORD_W-1:0];
    v.z = z[COORD_W-1:0];
    return v;
  endfunction

  function automatic vector_t vec(input setup_t cfg, input vertex_t pos, input bit typed,
                                  input vertex_t want = '0, input bit sat = 1'b0);
    vector_t t;
    t.cfg = cfg;
    t.pos = pos;
    t.typed = typed;
    t.result.pos = want;
    t.result.sat = sat;
    return t;
  endfunction

  function automatic reg_file_t reg_words(input setup_t s);
    reg_file_t w;
    w = '{COEF_BITS'(s.mode), COEF_BITS'(s.axis), s.param_x, s.param_y, s.param_z,
          s.coef_first, s.coef_second};
    return w;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return COORD_LO[COORD_W-1:0];
      1: return COORD_HI[COORD_W-1:0];
      2: return '0;
      3: return '1;
      4: return 16'sd1;
      5, 6: return COORD_W'($urandom_range(0, 200)) - 16'd100;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_BITS-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return FRAC_ONE[COEF_BITS-1:0];
      3: return -FRAC_ONE[COEF_BITS-1:0];
      4, 5, 6: return COEF_BITS'($urandom_range(0, 8192)) - 16'd4096;
      default: return COEF_BITS'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Wait until the pipeline is empty so the registers may change.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY) @(posedge clk_i);
  endtask

  task automatic load_setup(input setup_t next, input bit every);
    reg_file_t now_w;
    reg_file_t next_w;
    now_w  = reg_words(active);
    next_w = reg_words(next);
    for (int i = 0; i < 7; i++) begin
      if (every || now_w[i] != next_w[i]) begin
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_ORDER[i];
        cfg_data <= next_w[i];
        @(posedge clk_i);
      end
    end
    cfg_we <= 1'b0;
    active = next;
  endtask

  task automatic send_vertex(input vertex_t v, input bit typed, input transform_t result);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(typed ? result : predict_vertex(active, v));
    vertices_sent++;
  endtask

  // Output side: random backpressure plus an occasional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      holds_seen    <= 0;
    end else if (holds_seen != hold_requests) begin
      holds_seen    <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    transform_t got;
    transform_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pos = m_axis_tdata[3*COORD_W-1:0];
      got.sat = m_axis_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word x=%0d y=%0d z=%0d sat=%0b",
                                  got.pos.x, got.pos.y, got.pos.z, got.sat));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.pos.x !== want.pos.x)
          report_mismatch($sformatf("result %0d x_out %0d, expected %0d",
                                    results_checked, got.pos.x, want.pos.x));
        if (got.pos.y !== want.pos.y)
          report_mismatch($sformatf("result %0d y_out %0d, expected %0d",
                                    results_checked, got.pos.y, want.pos.y));
        if (got.pos.z !== want.pos.z)
          report_mismatch($sformatf("result %0d z_out %0d, expected %0d",
                                    results_checked, got.pos.z, want.pos.z));
        if (got.sat !== want.sat)
          report_mismatch($sformatf("result %0d saturated %0b, expected %0b",
                                    results_checked, got.sat, want.sat));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("vertex_affine_transform_3d_unit verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    vector_t plan [$];
    setup_t  reset_setup;
    setup_t  next;
    int      directed;
    int      phases;
    int      count;
    int      m;

    reset_setup = mk_setup(MODE_TRANSLATE, AXIS_X, 0, 0, 0, 4096, 0);
    active = reset_setup;

    // translate with reset registers, then offsets that clamp
    plan.push_back(vec(reset_setup, vtx(1, 2, 3), 1, vtx(1, 2, 3), 0));
    plan.push_back(vec(reset_setup, vtx(32767, -32768, 0), 1, vtx(32767, -32768, 0), 0));
    plan.push_back(vec(mk_setup(MODE_TRANSLATE, AXIS_X, 1, -1, 0, 4096, 0),
                       vtx(32767, -32768, 5), 1, vtx(32767, -32768, 5), 1));
    plan.push_back(vec(mk_setup(MODE_TRANSLATE, AXIS_X, -32768, 32767, -32768, 4096, 0),
                       vtx(-32768, 32767, 0), 1, vtx(-32768, 32767, -32768), 1));
    // scale
    plan.push_back(vec(mk_setup(MODE_SCALE, AXIS_X, 2, 3, -1, 4096, 0),
                       vtx(100, -200, -32768), 1, vtx(200, -600, 32767), 1));
    plan.push_back(vec(mk_setup(MODE_SCALE, AXIS_X, 32767, -32768, 0, 4096, 0),
                       vtx(32767, 32767, 7), 1, vtx(32767, -32768, 0), 1));
    // rotate: identity, quarter turns about each axis, spare axis, then extreme and 45-degree coefficients
    plan.push_back(vec(mk_setup(MODE_ROTATE, AXIS_Z, 0, 0, 0, 4096, 0),
                       vtx(10, -20, 30), 1, vtx(10, -20, 30), 0));
    plan.push_back(vec(mk_setup(MODE_ROTATE, AXIS_Z, 0, 0, 0, 0, 4096),
                       vtx(10, -20, 30), 1, vtx(20, 10, 30), 0));
    plan.push_back(vec(mk_setup(MODE_ROTATE, AXIS_Y, 0, 0, 0, 0, 4096),
                       vtx(10, -20, 30), 1, vtx(30, -20, -10), 0));
    plan.push_back(vec(mk_setup(MODE_ROTATE, AXIS_X, 0, 0, 0, 0, 4096),
                       vtx(10, -20, 30), 1, vtx(10, -30, -20), 0));
    plan.push_back(vec(mk_setup(MODE_ROTATE, AXIS_SPARE, 0, 0, 0, 0, 4096),
                       vtx(10, -20, 30), 1, vtx(10, -20, 30), 0));
    plan.push_back(vec(mk_setup(MODE_ROTATE, AXIS_Z, 0, 0, 0, -32768, 32767),
                       vtx(-32768, 32767, 0), 0));
    plan.push_back(vec(mk_setup(MODE_ROTATE, AXIS_Z, 0, 0, 0, 2896, 2896),
                       vtx(-7, 3, 0), 0));
    // reflect, including the most negative value and the spare axis
    plan.push_back(vec(mk_setup(MODE_REFLECT, AXIS_X, 0, 0, 0, 4096, 0),
                       vtx(-32768, 5, 6), 1, vtx(32767, 5, 6), 1));
    plan.push_back(vec(mk_setup(MODE_REFLECT, AXIS_Y, 0, 0, 0, 4096, 0),
                       vtx(1, -32768, 2), 1, vtx(1, 32767, 2), 1));
    plan.push_back(vec(mk_setup(MODE_REFLECT, AXIS_Z, 0, 0, 0, 4096, 0),
                       vtx(1, 2, -3), 1, vtx(1, 2, 3), 0));
    plan.push_back(vec(mk_setup(MODE_REFLECT, AXIS_SPARE, 0, 0, 0, 4096, 0),
                       vtx(1, 2, 3), 1, vtx(1, -2, 3), 0));
    // shear along each axis with unit factors, spare axis acts as Y, then small and extreme factors
    plan.push_back(vec(mk_setup(MODE_SHEAR, AXIS_Z, 0, 0, 0, 4096, -4096),
                       vtx(1, 2, 3), 1, vtx(4, -1, 3), 0));
    plan.push_back(vec(mk_setup(MODE_SHEAR, AXIS_X, 0, 0, 0, 4096, -4096),
                       vtx(1, 2, 3), 1, vtx(3, 2, 1), 0));
    plan.push_back(vec(mk_setup(MODE_SHEAR, AXIS_Y, 0, 0, 0, 4096, -4096),
                       vtx(1, 2, 3), 1, vtx(1, 3, 2), 0));
    plan.push_back(vec(mk_setup(MODE_SHEAR, AXIS_SPARE, 0, 0, 0, 4096, -4096),
                       vtx(1, 2, 3), 1, vtx(1, 3, 2), 0));
    plan.push_back(vec(mk_setup(MODE_SHEAR, AXIS_Z, 0, 0, 0, -1, 1), vtx(-5, 5, 3), 0));
    plan.push_back(vec(mk_setup(MODE_SHEAR, AXIS_Z, 0, 0, 0, 32767, -32768),
                       vtx(32767, -32768, 32767), 0));
    // spare modes pass the vertex through
    plan.push_back(vec(mk_setup(MODE_SPARE_FIRST, AXIS_X, 9, 9, 9, 4096, 0),
                       vtx(-32768, 32767, 1), 1, vtx(-32768, 32767, 1), 0));
    plan.push_back(vec(mk_setup(MODE_SPARE_LAST, AXIS_X, 9, 9, 9, 4096, 0),
                       vtx(32767, -32768, 0), 1, vtx(32767, -32768, 0), 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg != active) begin
        settle();
        load_setup(plan[i].cfg, 1'b0);
      end
      send_vertex(plan[i].pos, plan[i].typed, plan[i].result);
    end
    directed = vertices_sent;

    phases = 0;
    while (vertices_sent < directed + RANDOM_ITEMS) begin
      settle();
      if (phases == 0) begin
        next = mk_setup(MODE_TRANSLATE, AXIS_X, -32768, -32768, -32768, -32768, -32768);
      end else if (phases == 1) begin
        next = mk_setup(MODE_SHEAR, AXIS_SPARE, 32767, 32767, 32767, 32767, 32767);
      end else begin
        m = $urandom_range(0, 5);
        next.mode = (m == 5) ? MODE_BITS'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST))
                             : MODE_BITS'(m);
        next.axis = AXIS_BITS'($urandom_range(AXIS_X, AXIS_SPARE));
        next.param_x = pick_word();
        next.param_y = pick_word();
        next.param_z = pick_word();
        next.coef_first = pick_coef();
        next.coef_second = pick_coef();
      end
      load_setup(next, 1'b1);
      src_idle_pct = (phases == QUIET_PHASE) ? 0 : 33;
      sink_idle_pct <= (phases == QUIET_PHASE) ? 0 : 33;
      // stall the output long enough for the pipeline to push back on the input
      if (phases % 11 == 3) hold_requests <= hold_requests + 1;
      count = $urandom_range(40, 120);
      for (int k = 0; k < count; k++) begin
        send_vertex(vtx(pick_word(), pick_word(), pick_word()), 1'b0, '0);
      end
      phases++;
    end

    settle();
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    $display("covered %0d vertices (%0d directed) over %0d random register settings",
             vertices_sent, directed, phases);
    $display("compared %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("vertex_affine_transform_3d_unit verification clean");
    end else begin
      $display("vertex_affine_transform_3d_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/vat3d_pkg.sv
rtl/vat3d_opsel.sv
rtl/vat3d_lane.sv
rtl/vertex_affine_transform_3d_unit.sv
rtl/vat3d_checker.sv
tb/vertex_affine_transform_3d_unit_tb.sv
